// ----- design/rtlpm_pkg.sv -----
// types, constants and helper functions for the ipv4 longest-prefix-match route table
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rtlpm_pkg;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int PORT_W   = 8;
  localparam int METRIC_W = 5;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    prefix_len;
    logic [PORT_W-1:0]   out_port;
    logic [ADDR_W-1:0]   next_hop;
    logic [METRIC_W-1:0] route_metric;
  } rtlpm_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   found_hop;
    logic [PORT_W-1:0]   found_port;
    logic [METRIC_W-1:0] found_metric;
  } rtlpm_out_t;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [LEN_W-1:0]    len;
    logic [PORT_W-1:0]   port;
    logic [ADDR_W-1:0]   hop;
    logic [METRIC_W-1:0] metric;
  } rtlpm_entry_t;

  // search key held for the whole scan
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
  } rtlpm_key_t;

  // scan outcome from the compare unit
  typedef struct packed {
    logic                hit_found;
    logic                free_found;
    logic                best_found;
    logic [ADDR_W-1:0]   best_hop;
    logic [PORT_W-1:0]   best_port;
    logic [METRIC_W-1:0] best_metric;
  } rtlpm_scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } rtlpm_state_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    sat_len = (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = MAX_LEN - len;
    if (len == '0) begin
      len_mask = '0;
    end else if (len >= MAX_LEN) begin
      len_mask = '1;
    end else begin
      len_mask = {ADDR_W{1'b1}} << sh[4:0];
    end
  endfunction

endpackage

// ----- design/rtlpm_mem.sv -----
// route payload memory: one write port, one registered read port
// depends on rtlpm_pkg for the entry type
`timescale 1ns / 1ps

module rtlpm_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  rtlpm_pkg::rtlpm_entry_t wr_data,
  input  logic [IDX_W-1:0]      rd_addr,
  output rtlpm_pkg::rtlpm_entry_t rd_data
);
  import rtlpm_pkg::*;

  rtlpm_entry_t mem_r [DEPTH];
  rtlpm_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/rtlpm_cmp.sv -----
// shared compare unit: while en is high, checks one table entry per cycle against the key and
// keeps the exact-match slot, first free slot and best prefix seen so far; uses rtlpm_pkg
`timescale 1ns / 1ps

module rtlpm_cmp #(
  parameter int IDX_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  logic                    en,
  input  rtlpm_pkg::rtlpm_key_t   key,
  input  logic                    ent_valid,
  input  rtlpm_pkg::rtlpm_entry_t ent,
  input  logic [IDX_W-1:0]        ent_idx,
  output rtlpm_pkg::rtlpm_scan_t  scan,
  output logic [IDX_W-1:0]        slot
);
  import rtlpm_pkg::*;

  logic                hit_found_r;
  logic                free_found_r;
  logic                best_found_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [LEN_W-1:0]    best_len_r;
  logic [ADDR_W-1:0]   best_hop_r;
  logic [PORT_W-1:0]   best_port_r;
  logic [METRIC_W-1:0] best_metric_r;

  logic exact;
  logic qmatch;
  logic better;

  always_comb begin
    exact  = ent_valid && (ent.prefix == key.prefix) && (ent.len == key.len);
    qmatch = ent_valid && ((key.addr & len_mask(ent.len)) == ent.prefix);
    better = qmatch && (!best_found_r || (ent.len > best_len_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (clr) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (en) begin
      if (exact) begin
        hit_found_r <= 1'b1;
      end
      if (!ent_valid) begin
        free_found_r <= 1'b1;
      end
      if (better) begin
        best_found_r <= 1'b1;
      end
    end
  end

  // slot indexes and best payload only matter once their flag is set
  always_ff @(posedge clk) begin
    if (en) begin
      if (exact && !hit_found_r) begin
        hit_idx_r <= ent_idx;
      end
      if (!ent_valid && !free_found_r) begin
        free_idx_r <= ent_idx;
      end
      if (better) begin
        best_len_r    <= ent.len;
        best_hop_r    <= ent.hop;
        best_port_r   <= ent.port;
        best_metric_r <= ent.metric;
      end
    end
  end

  always_comb begin
    scan.hit_found   = hit_found_r;
    scan.free_found  = free_found_r;
    scan.best_found  = best_found_r;
    scan.best_hop    = best_hop_r;
    scan.best_port   = best_port_r;
    scan.best_metric = best_metric_r;
    slot             = hit_found_r ? hit_idx_r : free_idx_r;
  end

endmodule

// ----- design/rtlpm_seq.sv -----
// sequencer: accepts a command, sweeps the table one entry per cycle, then
// commits the update and registers the result; holds the valid bits; uses rtlpm_pkg
`timescale 1ns / 1ps

module rtlpm_seq #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rtlpm_pkg::rtlpm_in_t    in_item,
  output logic                    out_valid,
  output rtlpm_pkg::rtlpm_out_t   out_result,
  output logic [IDX_W-1:0]        rd_addr,
  output logic                    wr_en,
  output logic [IDX_W-1:0]        wr_addr,
  output rtlpm_pkg::rtlpm_entry_t wr_data,
  output logic                    cmp_clr,
  output logic                    cmp_en,
  output rtlpm_pkg::rtlpm_key_t   key,
  output logic                    ent_valid,
  output logic [IDX_W-1:0]        ent_idx,
  input  rtlpm_pkg::rtlpm_scan_t  scan,
  input  logic [IDX_W-1:0]        slot
);
  import rtlpm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  rtlpm_state_t state_r, state_nxt;

  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_d_r;
  logic                cmp_en_r;
  logic                ent_valid_r;
  logic [DEPTH-1:0]    valid_r;
  rtlpm_key_t          key_r;
  logic [PORT_W-1:0]   port_r;
  logic [ADDR_W-1:0]   hop_r;
  logic [METRIC_W-1:0] metric_r;
  logic                out_valid_r;
  rtlpm_out_t          out_r;

  logic       accept;
  logic       valid_set;
  logic       valid_clr;
  logic       finish;
  rtlpm_out_t result;
  logic [LEN_W-1:0] in_len;

  assign accept = start && (state_r == S_IDLE);
  assign in_len = sat_len(in_item.prefix_len);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (idx_r == LAST_IDX) state_nxt = S_LAST;
      S_LAST:   state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    finish    = (state_r == S_FINISH);
    cmp_clr   = accept;
    rd_addr   = idx_r;
    wr_addr   = slot;
    wr_data.prefix = key_r.prefix;
    wr_data.len    = key_r.len;
    wr_data.port   = port_r;
    wr_data.hop    = hop_r;
    wr_data.metric = metric_r;
    wr_en     = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    result    = '0;
    result.status = STATUS_OK;
    case (key_r.kind)
      KIND_INSERT: begin
        if (scan.hit_found || scan.free_found) begin
          wr_en     = finish;
          valid_set = finish;
        end else begin
          result.status = STATUS_FULL;
        end
      end
      KIND_DELETE: begin
        if (scan.hit_found) begin
          valid_clr = finish;
        end else begin
          result.status = STATUS_MISS;
        end
      end
      KIND_QUERY: begin
        if (scan.best_found) begin
          result.found_hop    = scan.best_hop;
          result.found_port   = scan.best_port;
          result.found_metric = scan.best_metric;
        end else begin
          result.status = STATUS_MISS;
        end
      end
      default: begin
        result.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_en_r    <= (state_r == S_SCAN);
      out_valid_r <= finish;
      if (accept || (state_r != S_SCAN)) begin
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
      if (valid_set) begin
        valid_r[slot] <= 1'b1;
      end else if (valid_clr) begin
        valid_r[slot] <= 1'b0;
      end
    end
  end

  // read-side alignment with the registered memory port, plus item payload
  always_ff @(posedge clk) begin
    idx_d_r     <= idx_r;
    ent_valid_r <= valid_r[idx_r];
    if (accept) begin
      key_r.kind   <= in_item.kind;
      key_r.addr   <= in_item.address;
      key_r.len    <= in_len;
      key_r.prefix <= in_item.address & len_mask(in_len);
      port_r       <= in_item.out_port;
      hop_r        <= in_item.next_hop;
      metric_r     <= in_item.route_metric;
    end
    if (finish) begin
      out_r <= result;
    end
  end

  assign cmp_en     = cmp_en_r;
  assign key        = key_r;
  assign ent_valid  = ent_valid_r;
  assign ent_idx    = idx_d_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

// ----- design/ipv4_route_table_lpm_top.sv -----
// top level of the ipv4 longest-prefix-match route table
// depends on rtlpm_pkg, rtlpm_mem, rtlpm_cmp and rtlpm_seq
`timescale 1ns / 1ps

// Route table of TABLE_DEPTH entries taking insert, delete and query commands.
// A command is taken when start is high and busy is low; busy then stays high
// while a single compare unit walks the table one entry per cycle through the
// registered read port of the route memory, and the last busy cycle writes the
// route or valid bit. The result shows on out_result for one cycle with
// out_valid high in the first cycle that busy is low, and must be taken then:
// there is no way to hold it. A new command may be started in that same cycle.
// The table is empty after reset with no clearing pass.
module ipv4_route_table_lpm_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rtlpm_pkg::rtlpm_in_t  in_item,
  output logic                  out_valid,
  output rtlpm_pkg::rtlpm_out_t out_result
);
  import rtlpm_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rtlpm_entry_t     wr_data;
  rtlpm_entry_t     rd_data;
  logic             cmp_clr;
  logic             cmp_en;
  rtlpm_key_t       key;
  logic             ent_valid;
  logic [IDX_W-1:0] ent_idx;
  rtlpm_scan_t      scan;
  logic [IDX_W-1:0] slot;

  rtlpm_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rtlpm_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cmp_clr),
    .en        (cmp_en),
    .key       (key),
    .ent_valid (ent_valid),
    .ent       (rd_data),
    .ent_idx   (ent_idx),
    .scan      (scan),
    .slot      (slot)
  );

  rtlpm_seq #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .cmp_clr    (cmp_clr),
    .cmp_en     (cmp_en),
    .key        (key),
    .ent_valid  (ent_valid),
    .ent_idx    (ent_idx),
    .scan       (scan),
    .slot       (slot)
  );

endmodule

// ----- tb/ipv4_route_table_lpm_top_tb.sv -----
// self-checking testbench for the ipv4 longest-prefix-match route table
// depends on rtlpm_pkg and ipv4_route_table_lpm_top; a scoreboard class mirrors the table
`timescale 1ns / 1ps

module ipv4_route_table_lpm_top_tb;
  import rtlpm_pkg::*;

  localparam int DEPTH          = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // mirrors the route table and holds the replies still owed by the block
  class lpm_scoreboard;
    bit           slot_used[DEPTH];
    rtlpm_entry_t slot_route[DEPTH];
    rtlpm_out_t   replies_due[$];
    int           error_count;

    static function logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
      return (len > 6'd32) ? 6'd32 : len;
    endfunction

    static function logic [ADDR_W-1:0] mask_for(logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      return {ADDR_W{1'b1}} << (32 - int'(len));
    endfunction

    function int find_route(logic [ADDR_W-1:0] prefix, logic [LEN_W-1:0] len);
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && slot_route[i].prefix == prefix && slot_route[i].len == len) return i;
      end
      return -1;
    endfunction

    function void note_command(rtlpm_in_t cmd);
      rtlpm_out_t        reply;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] prefix;
      int                slot;
      int                best_len;
      reply = '0;
      reply.status = STATUS_OK;
      len = clamp_len(cmd.prefix_len);
      prefix = cmd.address & mask_for(len);
      case (cmd.kind)
        KIND_INSERT: begin
          slot = find_route(prefix, len);
          for (int i = 0; i < DEPTH && slot < 0; i++) begin
            if (!slot_used[i]) slot = i;
          end
          if (slot < 0) begin
            reply.status = STATUS_FULL;
          end else begin
            slot_used[slot] = 1'b1;
            slot_route[slot].prefix = prefix;
            slot_route[slot].len    = len;
            slot_route[slot].port   = cmd.out_port;
            slot_route[slot].hop    = cmd.next_hop;
            slot_route[slot].metric = cmd.route_metric;
          end
        end
        KIND_DELETE: begin
          slot = find_route(prefix, len);
          if (slot < 0) reply.status = STATUS_MISS;
          else slot_used[slot] = 1'b0;
        end
        KIND_QUERY: begin
          slot = -1;
          best_len = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_used[i] && int'(slot_route[i].len) > best_len &&
                (cmd.address & mask_for(slot_route[i].len)) == slot_route[i].prefix) begin
              slot = i;
              best_len = int'(slot_route[i].len);
            end
          end
          if (slot < 0) begin
            reply.status = STATUS_MISS;
          end else begin
            reply.found_hop    = slot_route[slot].hop;
            reply.found_port   = slot_route[slot].port;
            reply.found_metric = slot_route[slot].metric;
          end
        end
        default: begin
        end
      endcase
      replies_due.insert(replies_due.size(), reply);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      error_count++;
    endtask

    task check_reply(rtlpm_out_t got);
      rtlpm_out_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected transaction status", 32'(got.status), 32'd0);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.found_hop !== want.found_hop)
        report_mismatch("found_hop", got.found_hop, want.found_hop);
      if (got.found_port !== want.found_port)
        report_mismatch("found_port", 32'(got.found_port), 32'(want.found_port));
      if (got.found_metric !== want.found_metric)
        report_mismatch("found_metric", 32'(got.found_metric), 32'(want.found_metric));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  rtlpm_in_t  in_item;
  logic       out_valid;
  rtlpm_out_t out_result;

  lpm_scoreboard sb = new();

  logic [ADDR_W-1:0] base_pool[16];
  rtlpm_in_t         route_log[$];
  int                gap_run_left;
  bit                no_idle;
  int                idle_cycles;

  ipv4_route_table_lpm_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // values read right after the edge are the ones the block sampled
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_reply(out_result);
      if (start && !busy) sb.note_command(in_item);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    if (gap_run_left == 0) begin
      gap_run_left = $urandom_range(10, 40);
      no_idle = ($urandom_range(0, 3) == 0);
    end
    gap_run_left--;
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic rtlpm_in_t route_cmd(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                          logic [LEN_W-1:0] len, logic [PORT_W-1:0] port,
                                          logic [ADDR_W-1:0] hop,
                                          logic [METRIC_W-1:0] metric);
    rtlpm_in_t cmd;
    cmd.kind = kind;
    cmd.address = addr;
    cmd.prefix_len = len;
    cmd.out_port = port;
    cmd.next_hop = hop;
    cmd.route_metric = metric;
    return cmd;
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    if ($urandom_range(0, 11) == 0) return LEN_W'($urandom_range(33, 63));
    return LEN_W'($urandom_range(0, 32));
  endfunction

  // random host bits under a random prefix of one of the pool bases
  function automatic logic [ADDR_W-1:0] near_address();
    logic [ADDR_W-1:0] keep;
    keep = lpm_scoreboard::mask_for(LEN_W'($urandom_range(0, 32)));
    return (base_pool[$urandom_range(0, 15)] & keep) | ($urandom & ~keep);
  endfunction

  // an address inside a route that was inserted earlier
  function automatic logic [ADDR_W-1:0] inside_logged(rtlpm_in_t route);
    logic [ADDR_W-1:0] keep;
    keep = lpm_scoreboard::mask_for(lpm_scoreboard::clamp_len(route.prefix_len));
    return (route.address & keep) | ($urandom & ~keep);
  endfunction

  function automatic void log_route(rtlpm_in_t cmd);
    route_log.insert(route_log.size(), cmd);
    if (route_log.size() > 80) void'(route_log.pop_front());
  endfunction

  function automatic rtlpm_in_t random_cmd(bit filling);
    rtlpm_in_t cmd;
    rtlpm_in_t prev;
    int        pick;
    cmd = route_cmd(KIND_QUERY, $urandom, random_len(), PORT_W'($urandom), $urandom,
                    METRIC_W'($urandom_range(0, 31)));
    if ($urandom_range(0, 4) == 0) cmd.next_hop = '0;
    pick = filling ? $urandom_range(0, 3) * 10 : $urandom_range(0, 99);
    if (pick < 35) begin
      cmd.kind = KIND_INSERT;
      if (filling) cmd.prefix_len = LEN_W'($urandom_range(16, 32));
      else cmd.address = near_address();
      log_route(cmd);
    end else if (pick < 55) begin
      cmd.kind = KIND_DELETE;
      if (route_log.size() > 0 && $urandom_range(0, 3) != 0) begin
        prev = route_log[$urandom_range(0, route_log.size() - 1)];
        cmd.address = inside_logged(prev);
        cmd.prefix_len = prev.prefix_len;
      end else begin
        cmd.address = near_address();
      end
    end else if (pick < 95) begin
      cmd.kind = KIND_QUERY;
      if (route_log.size() > 0 && $urandom_range(0, 1) == 0)
        cmd.address = inside_logged(route_log[$urandom_range(0, route_log.size() - 1)]);
      else if ($urandom_range(0, 4) != 0)
        cmd.address = near_address();
    end else begin
      cmd.kind = KIND_UNUSED;
    end
    return cmd;
  endfunction

  // start stays high across back-to-back commands
  task automatic send_command(input rtlpm_in_t cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    gap_run_left = 0;
    no_idle = 1'b0;
    foreach (base_pool[i]) base_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, default route, host bits, saturated length, odd metrics
    send_command(route_cmd(KIND_QUERY, 32'h0A010203, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_DELETE, 32'h0A000000, 6'd8, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_INSERT, 32'h12345678, 6'd0, 8'd1, 32'hC0A80001, 5'd1));
    send_command(route_cmd(KIND_QUERY, 32'hDEADBEEF, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_INSERT, 32'h0A010203, 6'd8, 8'd2, 32'hC0A80002, 5'd16));
    send_command(route_cmd(KIND_INSERT, 32'h0A010000, 6'd16, 8'd3, 32'd0, 5'd31));
    send_command(route_cmd(KIND_INSERT, 32'h0A01024D, 6'd32, 8'hFF, 32'hFFFFFFFF, 5'd0));
    send_command(route_cmd(KIND_INSERT, 32'h0A01024D, 6'd63, 8'd4, 32'h01020304, 5'd7));
    send_command(route_cmd(KIND_QUERY, 32'h0A01024D, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'h0A010909, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'h0AC80001, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'h0B000001, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_UNUSED, 32'hFFFFFFFF, 6'h3F, 8'hFF, 32'hFFFFFFFF, 5'h1F));
    send_command(route_cmd(KIND_DELETE, 32'h0AFFFFFF, 6'd8, 8'hFF, 32'hFFFFFFFF, 5'h1F));
    send_command(route_cmd(KIND_QUERY, 32'h0AC80001, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_DELETE, 32'h0A01024D, 6'd40, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'h0A01024D, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_INSERT, 32'hFFFFFFFF, 6'd0, 8'd9, 32'h0A0A0A0A, 5'd2));
    send_command(route_cmd(KIND_QUERY, 32'h00000000, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_DELETE, 32'h00000000, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_DELETE, 32'h0A010000, 6'd16, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'h0B000001, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_INSERT, 32'hFFFFFFFF, 6'd32, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_QUERY, 32'hFFFFFFFF, 6'd0, 8'd0, 32'd0, 5'd0));
    send_command(route_cmd(KIND_DELETE, 32'hFFFFFFFF, 6'd31, 8'd0, 32'd0, 5'd0));

    // mixed traffic around a handful of prefixes so lookups nest and deletes hit
    repeat (330) send_command(random_cmd(1'b0));
    drain_replies();

    // fill the table to overflow, then churn it
    repeat (90) send_command(random_cmd(1'b1));
    repeat (160) send_command(random_cmd(1'b0));

    drain_replies();
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
